/* hw/rtl/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the masked signature scanner
// Action and status codes, the built-in signature table and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int ACT_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_RESTORE = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_SIG     = 2'd2,
    ACT_SCAN    = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // built-in signature table
  localparam int BI_COUNT  = 4;
  localparam int BI_MAXLEN = 11;

  localparam logic [BYTE_W-1:0] BI_DATA [BI_COUNT][BI_MAXLEN] = '{
    '{8'h43, 8'h68, 8'h65, 8'h61, 8'h74, 8'h45, 8'h6E, 8'h67, 8'h69, 8'h6E, 8'h65},
    '{8'h8B, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h15, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h72, 8'h74, 8'h4D, 8'h6F, 8'h6E, 8'h65, 8'h79, 8'h00, 8'h00, 8'h00},
    '{8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h00}
  };
  localparam logic [BI_MAXLEN-1:0] BI_CARE [BI_COUNT] = '{
    11'b111_1111_1111,
    11'b000_1100_0011,
    11'b000_1111_1111,
    11'b011_1111_1111
  };
  localparam logic [3:0] BI_LEN [BI_COUNT] = '{4'd11, 4'd8, 4'd8, 4'd10};

  // {care, byte} of one built-in entry
  function automatic logic [BYTE_W:0] builtin_word(logic [1:0] slot, logic [3:0] k);
    logic [BYTE_W:0] w;
    w = '0;
    if (k < 4'(BI_MAXLEN)) begin
      w = {BI_CARE[slot][k], BI_DATA[slot][k]};
    end
    return w;
  endfunction

  typedef struct packed {
    logic capture;
    logic decode;
    logic rom_step;
    logic scan_start;
    logic sel_next;
    logic sel_enter;
    logic wr;
    logic scan_end;
    logic emit;
  } mss_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             last;
    logic             rom_done;
    logic             sel_done;
    logic             sel_empty;
    logic             k_zero;
    logic             out_free;
  } mss_stat_t;

endpackage

/* hw/rtl/mss_in_if.sv */
// ----------------------------------------------------------------------------
// mss_in_if: input word channel
// Valid/ready channel carrying one action word.
// ----------------------------------------------------------------------------
interface mss_in_if;
  import mss_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;
  logic              care;
  logic              last;

  modport source (output valid, action, data_byte, care, last, input ready);
  modport sink   (input valid, action, data_byte, care, last, output ready);
endinterface

/* hw/rtl/mss_out_if.sv */
// ----------------------------------------------------------------------------
// mss_out_if: result word channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface mss_out_if;
  import mss_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDX_W-1:0]  pattern_index;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  pattern_count;

  modport source (output valid, found, pattern_index, status, pattern_count, input ready);
  modport sink   (input valid, found, pattern_index, status, pattern_count, output ready);
endinterface

/* hw/rtl/masked_signature_scanner_unit.sv */
// ----------------------------------------------------------------------------
// masked_signature_scanner_unit: masked multi-signature byte scanner
// Stores up to MAX_PATTERNS wildcard-masked signatures and reports the
// lowest-numbered one found wholly inside each streamed region.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  in_if    in   action, data_byte, care, last
//  out_if   out  found, pattern_index, status, pattern_count
//
// For a region byte the sequencer visits each stored signature in turn: each
// signature position is one read and one write of the partial-match RAM, and
// the result hand-off follows at the end of a region.
// Restore reruns the 44-entry built-in reload.
// After reset the 44-entry built-in load runs before the first word is taken.
// A result waits in the output register; a word that yields the next result
// stalls in the hand-off state until that register is free.
module masked_signature_scanner_unit #(
  parameter int MAX_LEN      = 256,
  parameter int MAX_PATTERNS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  mss_in_if.sink    in_if,
  mss_out_if.source out_if
);
  import mss_pkg::*;

  mss_cmd_t  cmd;
  mss_stat_t stat;

  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mss_datapath #(.MAX_LEN(MAX_LEN), .MAX_PATTERNS(MAX_PATTERNS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (in_if.action),
    .data_byte_i     (in_if.data_byte),
    .care_i          (in_if.care),
    .last_i          (in_if.last),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .found_o         (out_if.found),
    .pattern_index_o (out_if.pattern_index),
    .status_o        (out_if.status),
    .pattern_count_o (out_if.pattern_count)
  );
endmodule

/* hw/rtl/mss_ram.sv */
// ----------------------------------------------------------------------------
// mss_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/mss_ctrl.sv */
// ----------------------------------------------------------------------------
// mss_ctrl: scanner sequencer
// Steps through boot load, decode, built-in reload, the per-byte match
// sweep and result hand-off.
// ----------------------------------------------------------------------------
module mss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mss_pkg::mss_stat_t  stat_i,
  output mss_pkg::mss_cmd_t   cmd_o
);
  import mss_pkg::*;

  localparam logic [2:0] S_BOOT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ROM    = 3'd3;
  localparam logic [2:0] S_SEL    = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_WR     = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_BOOT: begin
        cmd_o.rom_step = 1'b1;
        if (stat_i.rom_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (action_e'(stat_i.action))
          ACT_SCAN: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SEL;
          end
          ACT_RESTORE: state_d = S_ROM;
          ACT_CLEAR:   state_d = S_EMIT;
          ACT_SIG:     state_d = stat_i.last ? S_EMIT : S_IDLE;
          default:     state_d = S_IDLE;
        endcase
      end
      S_ROM: begin
        cmd_o.rom_step = 1'b1;
        if (stat_i.rom_done) state_d = S_EMIT;
      end
      S_SEL: begin
        priority if (stat_i.sel_done) begin
          cmd_o.scan_end = 1'b1;
          state_d        = stat_i.last ? S_EMIT : S_IDLE;
        end else if (stat_i.sel_empty) begin
          cmd_o.sel_next = 1'b1;
        end else begin
          cmd_o.sel_enter = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: state_d = S_WR;
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = stat_i.k_zero ? S_SEL : S_RD;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

/* hw/rtl/mss_datapath.sv */
// ----------------------------------------------------------------------------
// mss_datapath: signature table, match state and result register
// Holds the signature and partial-match RAMs, lengths, load state and
// the registered result word.
// ----------------------------------------------------------------------------
module mss_datapath #(
  parameter int MAX_LEN      = 256,
  parameter int MAX_PATTERNS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mss_pkg::mss_cmd_t            cmd_i,
  output mss_pkg::mss_stat_t           stat_o,
  input  logic [mss_pkg::ACT_W-1:0]    action_i,
  input  logic [mss_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                         care_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [mss_pkg::IDX_W-1:0]    pattern_index_o,
  output logic [mss_pkg::STAT_W-1:0]   status_o,
  output logic [mss_pkg::CNT_W-1:0]    pattern_count_o
);
  import mss_pkg::*;

  localparam int DEPTH = MAX_PATTERNS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_LEN);
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int PW    = $clog2(MAX_PATTERNS);
  localparam int PCW   = $clog2(MAX_PATTERNS + 1);

  // captured word
  logic [ACT_W-1:0]  act_q;
  logic [BYTE_W-1:0] byte_q;
  logic              care_q, last_q;

  // table and load state
  logic [LW-1:0]    len_q [MAX_PATTERNS];
  logic [CNT_W-1:0] total_q;
  logic [LW-1:0]    lpos_q;
  logic             lovf_q;

  // scan state
  logic                    first_q;
  logic [MAX_PATTERNS-1:0] mflags_q;
  logic [PCW-1:0]          p_q;
  logic [KW-1:0]           k_q;
  logic [1:0]              rs_q;
  logic [3:0]              rk_q;
  logic [STAT_W-1:0]       res_status_q;

  // result register
  logic              out_valid_q;
  logic              found_q;
  logic [IDX_W-1:0]  index_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  count_q;

  // RAM ports
  logic            sig_we, pm_we, pm_wdata;
  logic [AW-1:0]   sig_waddr, sig_raddr, pm_waddr, pm_raddr;
  logic [BYTE_W:0] sig_wdata, sig_rdata;
  logic            pm_rdata;

  logic [PW-1:0] p_idx;
  logic [LW-1:0] cur_len;
  logic [KW-1:0] k_top;
  logic          sig_room, pos_room, hit, prev, nv;
  logic [IDX_W-1:0] first_idx;

  assign p_idx    = p_q[PW-1:0];
  assign cur_len  = len_q[p_idx];
  assign k_top    = KW'(cur_len - LW'(1));
  assign sig_room = total_q < CNT_W'(MAX_PATTERNS);
  assign pos_room = lpos_q < LW'(MAX_LEN);

  function automatic logic [AW-1:0] addr(int slot, int k);
    return AW'(slot * MAX_LEN + k);
  endfunction

  // signature RAM write: built-in reload or appended byte
  always_comb begin
    sig_we    = 1'b0;
    sig_waddr = addr(int'(rs_q), int'(rk_q));
    sig_wdata = builtin_word(rs_q, rk_q);
    if (cmd_i.rom_step) begin
      sig_we = 1'b1;
    end else if (cmd_i.decode && act_q == ACT_SIG && pos_room && sig_room) begin
      sig_we    = 1'b1;
      sig_waddr = addr(int'(total_q[PW-1:0]), int'(lpos_q[KW-1:0]));
      sig_wdata = {care_q, byte_q};
    end
  end

  // match step for one position
  assign sig_raddr = addr(int'(p_idx), int'(k_q));
  assign pm_raddr  = addr(int'(p_idx), int'(k_q - KW'(1)));
  assign pm_waddr  = sig_raddr;
  assign hit       = !sig_rdata[BYTE_W] || (sig_rdata[BYTE_W-1:0] == byte_q);
  assign prev      = (k_q == '0) ? 1'b1 : (!first_q && pm_rdata);
  assign nv        = prev && hit;
  assign pm_we     = cmd_i.wr;
  assign pm_wdata  = nv;

  mss_ram #(.WIDTH(BYTE_W + 1), .DEPTH(DEPTH)) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (sig_we),
    .waddr_i (sig_waddr),
    .wdata_i (sig_wdata),
    .raddr_i (sig_raddr),
    .rdata_o (sig_rdata)
  );

  mss_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pm_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  // lowest matching signature
  always_comb begin
    first_idx = '0;
    for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
      if (mflags_q[i]) first_idx = IDX_W'(i);
    end
  end

  // status back to the sequencer
  always_comb begin
    stat_o.action    = act_q;
    stat_o.last      = last_q;
    stat_o.rom_done  = (rs_q == 2'(BI_COUNT - 1)) && (rk_q == 4'(BI_MAXLEN - 1));
    stat_o.sel_done  = CNT_W'(p_q) >= total_q;
    stat_o.sel_empty = (cur_len == '0);
    stat_o.k_zero    = (k_q == '0);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // captured word, position counter and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      byte_q <= data_byte_i;
      care_q <= care_i;
      last_q <= last_i;
    end
    if (cmd_i.sel_enter) k_q <= k_top;
    if (cmd_i.wr && k_q != '0) k_q <= k_q - KW'(1);
    if (cmd_i.emit) begin
      found_q  <= (act_q == ACT_SCAN) && (mflags_q != '0);
      index_q  <= (act_q == ACT_SCAN) ? first_idx : '0;
      status_q <= res_status_q;
      count_q  <= total_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        len_q[i] <= (i < BI_COUNT) ? LW'(BI_LEN[i]) : '0;
      end
      total_q      <= CNT_W'(BI_COUNT);
      lpos_q       <= '0;
      lovf_q       <= 1'b0;
      first_q      <= 1'b1;
      mflags_q     <= '0;
      p_q          <= '0;
      rs_q         <= '0;
      rk_q         <= '0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
    end else begin
      // built-in reload sweep, wraps back to zero
      if (cmd_i.rom_step) begin
        if (rk_q == 4'(BI_MAXLEN - 1)) begin
          rk_q <= '0;
          rs_q <= rs_q + 2'd1;
        end else begin
          rk_q <= rk_q + 4'd1;
        end
      end

      if (cmd_i.decode) begin
        res_status_q <= STAT_OK;
        if (act_q != ACT_SCAN) begin
          first_q  <= 1'b1;
          mflags_q <= '0;
        end
        unique case (action_e'(act_q))
          ACT_RESTORE: begin
            for (int i = 0; i < MAX_PATTERNS; i++) begin
              len_q[i] <= (i < BI_COUNT) ? LW'(BI_LEN[i]) : '0;
            end
            total_q <= CNT_W'(BI_COUNT);
            lpos_q  <= '0;
            lovf_q  <= 1'b0;
          end
          ACT_CLEAR: begin
            for (int i = 0; i < MAX_PATTERNS; i++) len_q[i] <= '0;
            total_q <= '0;
            lpos_q  <= '0;
            lovf_q  <= 1'b0;
          end
          ACT_SIG: begin
            if (pos_room) lpos_q <= lpos_q + LW'(1);
            else          lovf_q <= 1'b1;
            if (last_q) begin
              priority if (!sig_room) begin
                res_status_q <= STAT_FULL;
              end else if (lovf_q || !pos_room) begin
                res_status_q <= STAT_TOO_LONG;
              end else begin
                len_q[total_q[PW-1:0]] <= lpos_q + LW'(1);
                total_q                <= total_q + CNT_W'(1);
              end
              lpos_q <= '0;
              lovf_q <= 1'b0;
            end
          end
          ACT_SCAN: ;
          default: ;
        endcase
      end

      if (cmd_i.scan_start) p_q <= '0;
      if (cmd_i.sel_next) p_q <= p_q + PCW'(1);
      if (cmd_i.wr) begin
        if ((k_q == k_top) && nv) mflags_q[p_idx] <= 1'b1;
        if (k_q == '0) p_q <= p_q + PCW'(1);
      end
      if (cmd_i.scan_end) first_q <= 1'b0;

      // result hand-off
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (act_q == ACT_SCAN) begin
          first_q  <= 1'b1;
          mflags_q <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign pattern_index_o = index_q;
  assign status_o        = status_q;
  assign pattern_count_o = count_q;
endmodule
